/* rtl/core/oidl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// oidl_pkg
// Shared types and constants for the ordered id list engine.
// ============================================================================
package oidl_pkg;

  // List size and derived widths
  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int BTW_W     = 7;
  localparam int COUNT_MAX = 127;
  localparam int DIST_W    = (ADDR_W > BTW_W) ? ADDR_W : BTW_W;

  // Commands
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EQUAL     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] key_a;
    logic signed [KEY_W-1:0] key_b;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BTW_W-1:0]  between_count;
  } result_t;

  // Sequencer to list memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_SHIFT
  } seq_state_t;

endpackage
`default_nettype wire

/* rtl/core/oidl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// oidl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module oidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/oidl_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// oidl_seq
// Command sequencer: scans the list memory, shifts entries, builds results.
// ============================================================================
module oidl_seq import oidl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire request_t         request,
  output logic                  done,
  output result_t               result,
  output mem_req_t              mem_req,
  input  wire logic [KEY_W-1:0] rdata
);

  seq_state_t        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CMD_W-1:0]  cmd, cmd_next;
  logic [KEY_W-1:0]  key_a, key_a_next;
  logic [KEY_W-1:0]  key_b, key_b_next;
  logic [CNT_W-1:0]  idx, idx_next;      // next read index
  logic              pv, pv_next;        // read in flight
  logic [ADDR_W-1:0] pidx, pidx_next;    // index of read in flight
  logic              found_a, found_a_next;
  logic              found_b, found_b_next;
  logic [ADDR_W-1:0] pos_a, pos_a_next;
  logic [ADDR_W-1:0] pos_b, pos_b_next;
  logic              res_valid, res_valid_next;
  result_t           res, res_next;

  assign busy   = (state != SEQ_IDLE);
  assign done   = res_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      count     <= '0;
      pv        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pv        <= pv_next;
      res_valid <= res_valid_next;
    end
    cmd     <= cmd_next;
    key_a   <= key_a_next;
    key_b   <= key_b_next;
    idx     <= idx_next;
    pidx    <= pidx_next;
    found_a <= found_a_next;
    found_b <= found_b_next;
    pos_a   <= pos_a_next;
    pos_b   <= pos_b_next;
    res     <= res_next;
  end

  always_comb begin
    logic              match_a;
    logic              match_b;
    logic              hit;
    logic              issue;
    logic              ins;
    logic [CNT_W-1:0]  at;
    logic [ADDR_W-1:0] diff;
    logic [DIST_W-1:0] span;

    state_next     = state;
    count_next     = count;
    cmd_next       = cmd;
    key_a_next     = key_a;
    key_b_next     = key_b;
    idx_next       = idx;
    pv_next        = pv;
    pidx_next      = pidx;
    found_a_next   = found_a;
    found_b_next   = found_b;
    pos_a_next     = pos_a;
    pos_b_next     = pos_b;
    res_valid_next = 1'b0;
    res_next       = res;

    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = '0;
    mem_req.raddr = idx[ADDR_W-1:0];

    match_a = pv && (rdata == key_a);
    match_b = pv && (rdata == key_b);
    ins     = (cmd == CMD_INSERT);
    at      = CNT_W'(pos_a) + CNT_W'(1);
    hit     = ins ? match_b : match_a;
    issue   = 1'b0;
    diff    = (pos_a > pos_b) ? (pos_a - pos_b) : (pos_b - pos_a);
    span    = DIST_W'(diff) - DIST_W'(1);

    case (state)
      SEQ_IDLE: begin
        if (start) begin
          cmd_next     = request.command;
          key_a_next   = request.key_a;
          key_b_next   = request.key_b;
          idx_next     = '0;
          pv_next      = 1'b0;
          found_a_next = 1'b0;
          found_b_next = 1'b0;
          res_next.between_count = '0;
          case (request.command)
            CMD_APPEND: begin
              res_valid_next = 1'b1;
              if (count == CNT_W'(CAPACITY)) begin
                res_next.status = STAT_FULL;
              end else begin
                mem_req.we      = 1'b1;
                mem_req.waddr   = count[ADDR_W-1:0];
                mem_req.wdata   = request.key_a;
                count_next      = count + CNT_W'(1);
                res_next.status = STAT_OK;
              end
            end
            CMD_INSERT: begin
              if (count == CNT_W'(CAPACITY)) begin
                res_valid_next  = 1'b1;
                res_next.status = STAT_FULL;
              end else begin
                state_next = SEQ_SCAN;
              end
            end
            CMD_REMOVE: begin
              state_next = SEQ_SCAN;
            end
            CMD_COUNT: begin
              if (request.key_a == request.key_b) begin
                res_valid_next  = 1'b1;
                res_next.status = STAT_EQUAL;
              end else begin
                state_next = SEQ_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      SEQ_SCAN: begin
        issue = (idx < count);
        if (cmd == CMD_COUNT) begin
          if (match_a) begin
            found_a_next = 1'b1;
            pos_a_next   = pidx;
          end
          if (match_b) begin
            found_b_next = 1'b1;
            pos_b_next   = pidx;
          end
          if (!issue && !pv) begin
            state_next     = SEQ_IDLE;
            res_valid_next = 1'b1;
            if (found_a && found_b) begin
              res_next.status        = STAT_OK;
              res_next.between_count = (span > DIST_W'(COUNT_MAX)) ?
                                       BTW_W'(COUNT_MAX) : span[BTW_W-1:0];
            end else begin
              res_next.status = STAT_NOT_FOUND;
            end
          end else begin
            pv_next   = issue;
            pidx_next = idx[ADDR_W-1:0];
            if (issue) begin
              idx_next = idx + CNT_W'(1);
            end
          end
        end else begin
          if (hit) begin
            pos_a_next = pidx;
            pv_next    = 1'b0;
            state_next = SEQ_SHIFT;
            idx_next   = ins ? (count - CNT_W'(1)) : (CNT_W'(pidx) + CNT_W'(1));
          end else if (!issue && !pv) begin
            state_next      = SEQ_IDLE;
            res_valid_next  = 1'b1;
            res_next.status = STAT_NOT_FOUND;
          end else begin
            pv_next   = issue;
            pidx_next = idx[ADDR_W-1:0];
            if (issue) begin
              idx_next = idx + CNT_W'(1);
            end
          end
        end
      end

      SEQ_SHIFT: begin
        // insert walks down from the tail, remove walks up from the hole
        issue = ins ? (idx >= at) : (idx < count);
        if (pv) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ins ? (pidx + ADDR_W'(1)) : (pidx - ADDR_W'(1));
          mem_req.wdata = rdata;
        end
        pv_next   = issue;
        pidx_next = idx[ADDR_W-1:0];
        if (issue) begin
          idx_next = ins ? (idx - CNT_W'(1)) : (idx + CNT_W'(1));
        end
        if (!issue && !pv) begin
          if (ins) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = at[ADDR_W-1:0];
            mem_req.wdata = key_a;
            count_next    = count + CNT_W'(1);
          end else begin
            count_next = count - CNT_W'(1);
          end
          state_next      = SEQ_IDLE;
          res_valid_next  = 1'b1;
          res_next.status = STAT_OK;
        end
      end

      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/ordered_id_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ordered_id_list_engine
// Ordered list of up to CAPACITY 32-bit ids held in one RAM.
// ============================================================================
// A transaction is taken when start is high and busy is low. Its result
// shows on result for exactly one cycle with done high, in the cycle after
// the command completes; it cannot be held off, so capture it when done is
// seen. Append and the early answers (full list, equal references) are
// given straight from idle and leave busy low. Insert, remove and count walk
// the list through the single RAM read port at one entry per cycle. An
// insert or remove search ends at its first hit, a count scans every entry,
// and the shift after an insert or remove hit moves the entries behind it
// one place; the longest transaction is removing the head of a full list.
// No reset sweep is needed: only the first entry_count entries are ever
// read.
// ============================================================================
module ordered_id_list_engine import oidl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t request,
  output logic          done,
  output result_t       result
);

  mem_req_t         mem_req;
  logic [KEY_W-1:0] rdata;

  // Sequencer: search, shift and result build. During a shift, reads and
  // writes never touch the same entry in one cycle (shifts move away from
  // the read pointer), so the RAM needs no forwarding.
  oidl_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // List storage, contents undefined until written
  oidl_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_list_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

endmodule
`default_nettype wire

/* rtl/core/oidl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// oidl_checker
// Port-level checks on transactions of the ordered id list engine.
// ============================================================================
module oidl_checker import oidl_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire result_t  result
);

  // an accepted transaction either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted transaction neither busy nor answered");

  // a result only follows work or an acceptance
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start && !busy))
    else $error("result without a transaction");

  // leaving busy always delivers the result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy ended without a result");

  // distance only on a successful count
  a_between_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != STAT_OK) |-> (result.between_count == '0))
    else $error("between_count nonzero on failure");

  a_between_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(result.between_count) <= CAPACITY))
    else $error("between_count beyond list size");

endmodule

bind ordered_id_list_engine oidl_checker u_oidl_checker (.*);
`default_nettype wire

/* bench/tb_ordered_id_list_engine.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_ordered_id_list_engine
// Self-checking bench for the ordered id list engine: a shadow list predicts
// the status and distance of every transaction, which are then checked.
// ============================================================================
// The bench keeps its own copy of the list as a queue and applies each
// accepted transaction to it at the edge of acceptance, so the expected
// result is known before the engine answers. Results come back in order,
// one per transaction, and are checked against the oldest expectation.
//
// Stimulus runs in three parts:
//   - a short directed sequence: empty-list misses, extreme ids, head and
//     tail inserts and removes, duplicates, equal and absent references;
//   - random segments that grow the list, shrink it, mix commands, fill it
//     to capacity (then hammer it while full) or drain it to empty;
//   - idle phases: none, then sender idle weights of 81 and 27 percent, with
//     stretches of back-to-back transactions inside every phase.
// The receiver side cannot stall (done is a one-cycle strobe).
// ============================================================================
module tb_ordered_id_list_engine;
  import oidl_pkg::*;

  localparam int ITEMS     = 1900;
  localparam int MAX_GAP   = 30;     // longest sender pause, in cycles
  localparam int DRAIN_MAX = 10000;  // cycles allowed for results to come home
  localparam int TAIL_WAIT = 80;     // beyond the worst transaction latency

  typedef enum int {
    MODE_FILL,
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIXED,
    MODE_DRAIN
  } seg_mode_t;

  // --------------------------------------------------------------------------
  // Shadow list and store of awaited results
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [KEY_W-1:0] ids[$];
    result_t          awaited[$];
    int               failures;

    function new();
      failures = 0;
    endfunction

    function int first_index(logic [KEY_W-1:0] k);
      for (int i = 0; i < ids.size(); i++)
        if (ids[i] == k) return i;
      return -1;
    endfunction

    function int last_index(logic [KEY_W-1:0] k);
      int pos;
      pos = -1;
      for (int i = 0; i < ids.size(); i++)
        if (ids[i] == k) pos = i;
      return pos;
    endfunction

    // Apply one accepted transaction to the shadow list, queue its result
    function void note(request_t r);
      result_t want;
      int      p;
      int      q;
      int      span;
      want.status        = STAT_OK;
      want.between_count = '0;
      case (r.command)
        CMD_APPEND: begin
          if (ids.size() >= CAPACITY) want.status = STAT_FULL;
          else ids.push_back(r.key_a);
        end
        CMD_INSERT: begin
          // full check goes ahead of the reference search
          if (ids.size() >= CAPACITY) begin
            want.status = STAT_FULL;
          end else begin
            p = first_index(r.key_b);
            if (p < 0) want.status = STAT_NOT_FOUND;
            else ids.insert(p + 1, r.key_a);
          end
        end
        CMD_REMOVE: begin
          p = first_index(r.key_a);
          if (p < 0) want.status = STAT_NOT_FOUND;
          else ids.delete(p);
        end
        default: begin
          if (r.key_a == r.key_b) begin
            want.status = STAT_EQUAL;
          end else begin
            p = last_index(r.key_a);
            q = last_index(r.key_b);
            if (p < 0 || q < 0) begin
              want.status = STAT_NOT_FOUND;
            end else begin
              span = (p > q) ? p - q - 1 : q - p - 1;
              if (span > COUNT_MAX) span = COUNT_MAX;
              want.between_count = BTW_W'(span);
            end
          end
        end
      endcase
      awaited.push_back(want);
    endfunction

    function void check(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, status %0d count %0d",
                 $time, got.status, got.between_count);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, want.status, got.status);
        failures++;
      end
      if (got.between_count !== want.between_count) begin
        $display("%0t: between_count mismatch, expected %0d, got %0d",
                 $time, want.between_count, got.between_count);
        failures++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int size();
      return ids.size();
    endfunction

    function logic [KEY_W-1:0] entry(int i);
      return ids[i];
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  list_scoreboard   sb;
  int               sent;
  logic [KEY_W-1:0] key_pool[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordered_id_list_engine dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Results cannot be held off: take each one on the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check(result);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic request_t make_req(logic [CMD_W-1:0] cmd,
                                        logic [KEY_W-1:0] ka,
                                        logic [KEY_W-1:0] kb);
    request_t r;
    r.command = cmd;
    r.key_a   = ka;
    r.key_b   = kb;
    return r;
  endfunction

  // Present one transaction, hold start until it is taken. start is left
  // high afterwards so a follow-on transaction can go back to back.
  task automatic send(input request_t r, input int idle_pct);
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note(r);
    sent++;
  endtask

  // Sender holds off until every outstanding result is home
  task automatic wait_quiet();
    int n;
    n = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && n < DRAIN_MAX) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sb.size() > 0 && sel < 55) return sb.entry($urandom_range(sb.size() - 1));
    if (sel < 85) return key_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  // weights in percent; the remainder goes to count
  function automatic logic [CMD_W-1:0] pick_command(int w_app, int w_ins, int w_rem);
    int sel;
    sel = $urandom_range(99);
    if (sel < w_app) return CMD_APPEND;
    if (sel < w_app + w_ins) return CMD_INSERT;
    if (sel < w_app + w_ins + w_rem) return CMD_REMOVE;
    return CMD_COUNT;
  endfunction

  function automatic request_t random_item(logic [CMD_W-1:0] cmd);
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    ka = pick_key();
    kb = pick_key();
    if (cmd == CMD_COUNT) begin
      // head-to-tail counts give the widest distances; a few equal refs too
      if (sb.size() > 1 && $urandom_range(99) < 20) begin
        ka = sb.entry(0);
        kb = sb.entry(sb.size() - 1);
      end else if ($urandom_range(99) < 6) begin
        kb = ka;
      end
    end
    return make_req(cmd, ka, kb);
  endfunction

  task automatic run_segment(input seg_mode_t mode, input int idle_pct);
    int               len;
    int               extra;
    logic [CMD_W-1:0] cmd;
    // fresh ids for this segment, extremes always on hand
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom();
    len = $urandom_range(20, 60);
    case (mode)
      MODE_FILL: begin
        while (sb.size() < CAPACITY)
          send(random_item(pick_command(70, 30, 0)), idle_pct);
        // the list is full: appends and inserts must bounce
        for (extra = 0; extra < 10; extra++)
          send(random_item(pick_command(30, 30, 0)), idle_pct);
      end
      MODE_DRAIN: begin
        while (sb.size() > 0)
          send(make_req(CMD_REMOVE, sb.entry($urandom_range(sb.size() - 1)),
                        $urandom()), idle_pct);
        for (extra = 0; extra < 6; extra++)
          send(random_item(pick_command(0, 40, 30)), idle_pct);
      end
      default: begin
        for (int i = 0; i < len; i++) begin
          case (mode)
            MODE_GROW:   cmd = pick_command(40, 30, 10);
            MODE_SHRINK: cmd = pick_command(10, 10, 55);
            default:     cmd = pick_command(25, 25, 25);
          endcase
          send(random_item(cmd), idle_pct);
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int phase_idle[3];
    int idle;
    int n;
    seg_mode_t mode;
    phase_idle = '{0, 81, 27};
    sb   = new();
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list first
    send(make_req(CMD_REMOVE, 32'd5, 32'd0), 0);               // nothing to find
    send(make_req(CMD_COUNT, 32'd1, 32'd2), 0);                // empty list
    send(make_req(CMD_COUNT, 32'd9, 32'd9), 0);                // equal refs win
    send(make_req(CMD_INSERT, 32'd1, 32'd2), 0);               // no reference
    // extreme ids
    send(make_req(CMD_APPEND, 32'h8000_0000, 32'hFFFF_FFFF), 0);
    send(make_req(CMD_APPEND, 32'h7FFF_FFFF, 32'h0000_0000), 0);
    send(make_req(CMD_APPEND, 32'h0000_0000, 32'h8000_0000), 3);
    send(make_req(CMD_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 0);
    send(make_req(CMD_INSERT, 32'h5555_5555, 32'h8000_0000), 0);  // after head
    send(make_req(CMD_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFFF), 0);  // after tail
    send(make_req(CMD_COUNT, 32'h8000_0000, 32'hAAAA_AAAA), 0);
    send(make_req(CMD_COUNT, 32'hAAAA_AAAA, 32'h8000_0000), 2);   // reversed
    send(make_req(CMD_COUNT, 32'h0000_0000, 32'hFFFF_FFFF), 0);   // adjacent
    // duplicates: insert and remove use the first, count the last
    send(make_req(CMD_APPEND, 32'h0000_0000, 32'h1234_5678), 0);
    send(make_req(CMD_COUNT, 32'h8000_0000, 32'h0000_0000), 0);
    send(make_req(CMD_INSERT, 32'h1234_5678, 32'h0000_0000), 0);
    send(make_req(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000), 1);
    send(make_req(CMD_REMOVE, 32'h8000_0000, 32'h0000_0000), 0);  // head
    send(make_req(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000), 0);  // tail
    send(make_req(CMD_REMOVE, 32'h1357_9BDF, 32'h0000_0000), 0);  // absent
    send(make_req(CMD_COUNT, 32'h7FFF_FFFF, 32'h2468_ACE0), 0);   // one absent
    send(make_req(CMD_COUNT, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    wait_quiet();

    // Random segments across the idle phases
    for (int ph = 0; ph < 3; ph++) begin
      n = 0;
      while (sent < (ph + 1) * ITEMS / 3) begin
        // one segment in five runs with no idling at all
        idle = ($urandom_range(4) == 0) ? 0 : phase_idle[ph];
        // every phase begins by filling the list to capacity
        if (n == 0) mode = MODE_FILL;
        else mode = seg_mode_t'($urandom_range(4));
        run_segment(mode, idle);
        n++;
      end
      wait_quiet();
    end

    // Everything sent; let the last results arrive, then a little more
    wait_quiet();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d results never arrived", $time, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_ordered_id_list_engine OK");
    end else begin
      $display("tb_ordered_id_list_engine NOT OK");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_ordered_id_list_engine NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/oidl_pkg.sv
rtl/core/oidl_ram.sv
rtl/core/oidl_seq.sv
rtl/core/ordered_id_list_engine.sv
rtl/core/oidl_checker.sv
bench/tb_ordered_id_list_engine.sv
